FILE: rtl/core/tpmq_pkg.sv
// Shared types and constants for the tree path minimum query block.
// Depends on nothing; every module of the block imports it.
package tpmq_pkg;

  localparam int ID_W     = 10;
  localparam int WEIGHT_W = 24;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONES = {WEIGHT_W{1'b1}};

  // Item kinds carried on s_tuser.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef logic [ID_W-1:0]     node_id_t;
  typedef logic [WEIGHT_W-1:0] weight_t;

  function automatic weight_t wmin(input weight_t x, input weight_t y);
    return (x < y) ? x : y;
  endfunction

endpackage

FILE: rtl/core/tpmq_depth_store.sv
// Node depth memory with a clearing pass after reset.
// Depends on tpmq_pkg; used by tree_path_minimum_query.
module tpmq_depth_store import tpmq_pkg::*; #(
  parameter int MAX_NODES = 1024,
  parameter int NW = 10,
  parameter int DW = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [NW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [NW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  output logic          busy
);

  logic [DW-1:0] mem [MAX_NODES];
  logic [NW-1:0] clr_cnt;

  // Clearing pass: every depth becomes zero except the root, which gets one.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_cnt <= '0;
    end else if (busy) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == NW'(MAX_NODES - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Single write port shared by the clearing pass and inserts.
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_cnt] <= (clr_cnt == NW'(1)) ? DW'(1) : '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/core/tpmq_lift_store.sv
// Ancestor and level minimum memory, one entry per node and level.
// Depends on tpmq_pkg; rows of nodes zero and one read as the sentinel row.
module tpmq_lift_store import tpmq_pkg::*; #(
  parameter int MAX_NODES = 1024,
  parameter int NW = 10,
  parameter int LW = 4
) (
  input  logic          clk,
  input  logic [NW-1:0] rd_node,
  input  logic [LW-1:0] rd_lvl,
  output logic [NW-1:0] rd_anc,
  output weight_t       rd_min,
  input  logic          wr_en,
  input  logic [NW-1:0] wr_node,
  input  logic [LW-1:0] wr_lvl,
  input  logic [NW-1:0] wr_anc,
  input  weight_t       wr_min
);

  localparam int DEPTH = MAX_NODES * (1 << LW);
  localparam int EW    = NW + WEIGHT_W;

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] q;
  logic          sentinel_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[{wr_node, wr_lvl}] <= {wr_anc, wr_min};
    end
    q          <= mem[{rd_node, rd_lvl}];
    sentinel_q <= (rd_node < NW'(2));
  end

  // Nodes zero and one are never written: ancestor zero, weight all ones.
  assign rd_anc = sentinel_q ? '0 : q[EW-1:WEIGHT_W];
  assign rd_min = sentinel_q ? WEIGHT_ONES : q[WEIGHT_W-1:0];

endmodule

FILE: rtl/core/tree_path_minimum_query.sv
// Tree path minimum query block: sequencer over the depth and lift memories.
// Depends on tpmq_pkg, tpmq_depth_store and tpmq_lift_store.
//
// Usage: items enter on the s_ group. s_tuser is the kind (insert or query).
// An insert adds a node below a present parent and yields no result. A query
// yields one result on the m_ group: the smallest edge weight on the path
// between its two nodes, with m_tuser set when both nodes are the same.
// One item is worked on at a time. An insert's pace is bounded by the lift
// memory read per level. A query's pace is set by the single read port of
// each memory: each level of the climb waits for a lift read and then a
// depth read, and each level of the joint climb reads both rows in turn.
// Invalid or trivial items skip the climbs. After reset the depth memory is
// cleared, one entry a cycle; s_tready stays low meanwhile. A finished result
// waits in the output register while m_tready is low; the next item is still
// accepted and worked on, and only the delivery of its result waits for the
// register to free.
module tree_path_minimum_query import tpmq_pkg::*; #(
  parameter int MAX_NODES = 1024,
  parameter int LEVELS = 11
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // node[9:0], parent[19:10], weight[43:20], first_node[53:44], second_node[63:54]
  input  logic [63:0] s_tdata,
  // op[0]
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // path_minimum[23:0]
  output logic [23:0] m_tdata,
  // empty_path[0]
  output logic        m_tuser
);

  localparam int NW = $clog2(MAX_NODES);
  localparam int DW = $clog2(MAX_NODES + 1);
  localparam int LW = $clog2(LEVELS);

  typedef enum logic [3:0] {
    S_IDLE, S_I_D0, S_I_D1, S_I_D2, S_I_RD, S_I_WR,
    S_Q_DA, S_Q_DB, S_Q_SW, S_U_RD, S_U_DP, S_U_CMP,
    S_V_RA, S_V_RB, S_V_CMP, S_DONE
  } state_t;

  state_t        state;
  logic [NW-1:0] na, nb, par;
  logic [DW-1:0] da;
  logic [LW-1:0] lvl;
  logic [NW-1:0] anc_cur, up;
  weight_t       min_cur, up_min, best, a_min;
  logic [NW-1:0] a_anc;
  logic          fin, res_empty;

  logic [NW-1:0] d_rd_addr;
  logic [DW-1:0] d_rd_data;
  logic          d_wr_en, d_busy;
  logic [NW-1:0] l_rd_node, l_rd_anc;
  logic [LW-1:0] l_rd_lvl, l_wr_lvl;
  weight_t       l_rd_min;
  logic          l_wr_en;
  logic [NW-1:0] l_wr_anc;
  weight_t       l_wr_min;

  node_id_t f_node, f_par, f_first, f_second;
  weight_t  f_weight;
  logic     s_accept;

  assign f_node   = s_tdata[9:0];
  assign f_par    = s_tdata[19:10];
  assign f_weight = s_tdata[43:20];
  assign f_first  = s_tdata[53:44];
  assign f_second = s_tdata[63:54];

  assign s_tready = (state == S_IDLE) && !d_busy;
  assign s_accept = s_tvalid && s_tready;

  // Memory addressing follows the state; read data is registered and lands in the next cycle.
  always_comb begin
    d_rd_addr = na;
    l_rd_node = nb;
    l_rd_lvl  = lvl;
    d_wr_en   = 1'b0;
    l_wr_en   = 1'b0;
    l_wr_lvl  = lvl;
    l_wr_anc  = l_rd_anc;
    l_wr_min  = wmin(min_cur, l_rd_min);
    unique case (state)
      S_I_D1:  d_rd_addr = par;
      S_I_D2: begin
        d_wr_en  = (d_rd_data != '0);
        l_wr_en  = (d_rd_data != '0);
        l_wr_lvl = '0;
        l_wr_anc = par;
        l_wr_min = min_cur;
      end
      S_I_RD:  begin
        l_rd_node = anc_cur;
        l_rd_lvl  = lvl - 1'b1;
      end
      S_I_WR:  l_wr_en = 1'b1;
      S_Q_DB:  d_rd_addr = nb;
      S_U_DP:  d_rd_addr = l_rd_anc;
      S_V_RA:  l_rd_node = na;
      default: ;
    endcase
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: if (s_accept) begin
          nb      <= NW'(32'(f_second));
          par     <= NW'(32'(f_par));
          min_cur <= f_weight;
          best    <= WEIGHT_ONES;
          if (s_tuser == OP_INSERT) begin
            // The node index is kept in na during an insert.
            na <= NW'(32'(f_node));
            if (f_node >= ID_W'(2) && 32'(f_node) < MAX_NODES &&
                32'(f_par) < MAX_NODES) begin
              state <= S_I_D0;
            end
          end else begin
            na        <= NW'(32'(f_first));
            res_empty <= (f_first == f_second);
            if (f_first == f_second || 32'(f_first) >= MAX_NODES ||
                32'(f_second) >= MAX_NODES) begin
              state <= S_DONE;
            end else begin
              state <= S_Q_DA;
            end
          end
        end
        S_I_D0: state <= S_I_D1;
        S_I_D1: state <= (d_rd_data != '0) ? S_IDLE : S_I_D2;
        S_I_D2: begin
          anc_cur <= par;
          lvl     <= LW'(1);
          state   <= (d_rd_data == '0) ? S_IDLE : S_I_RD;
        end
        S_I_RD: state <= S_I_WR;
        S_I_WR: begin
          anc_cur <= l_rd_anc;
          min_cur <= l_wr_min;
          lvl     <= lvl + 1'b1;
          state   <= (lvl == LW'(LEVELS - 1)) ? S_IDLE : S_I_RD;
        end
        S_Q_DA: state <= S_Q_DB;
        S_Q_DB: begin
          da    <= d_rd_data;
          state <= S_Q_SW;
        end
        S_Q_SW: begin
          lvl <= LW'(LEVELS - 1);
          if (da == '0 || d_rd_data == '0) begin
            state <= S_DONE;
          end else begin
            // The deeper end climbs; keep it in nb.
            if (da > d_rd_data) begin
              na <= nb;
              nb <= na;
              da <= d_rd_data;
            end
            state <= S_U_RD;
          end
        end
        S_U_RD: state <= S_U_DP;
        S_U_DP: begin
          up     <= l_rd_anc;
          up_min <= l_rd_min;
          state  <= S_U_CMP;
        end
        S_U_CMP: begin
          logic          take;
          logic [NW-1:0] b_new;
          take  = (d_rd_data >= da);
          b_new = take ? up : nb;
          if (take) begin
            best <= wmin(best, up_min);
            nb   <= up;
          end
          if (lvl == '0) begin
            lvl   <= LW'(LEVELS - 1);
            fin   <= 1'b0;
            state <= (b_new == na) ? S_DONE : S_V_RA;
          end else begin
            lvl   <= lvl - 1'b1;
            state <= S_U_RD;
          end
        end
        S_V_RA: state <= S_V_RB;
        S_V_RB: begin
          a_anc <= l_rd_anc;
          a_min <= l_rd_min;
          state <= S_V_CMP;
        end
        S_V_CMP: begin
          if (fin) begin
            best  <= wmin(best, wmin(a_min, l_rd_min));
            state <= S_DONE;
          end else begin
            if (a_anc != l_rd_anc) begin
              best <= wmin(best, wmin(a_min, l_rd_min));
              na   <= a_anc;
              nb   <= l_rd_anc;
            end
            if (lvl == '0) begin
              fin <= 1'b1;
            end else begin
              lvl <= lvl - 1'b1;
            end
            state <= S_V_RA;
          end
        end
        S_DONE: if (!m_tvalid || m_tready) begin
          m_tvalid <= 1'b1;
          m_tdata  <= best;
          m_tuser  <= res_empty;
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  tpmq_depth_store #(.MAX_NODES(MAX_NODES), .NW(NW), .DW(DW)) u_depth (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (d_rd_addr),
    .rd_data (d_rd_data),
    .wr_en   (d_wr_en),
    .wr_addr (na),
    .wr_data (d_rd_data + 1'b1),
    .busy    (d_busy)
  );

  tpmq_lift_store #(.MAX_NODES(MAX_NODES), .NW(NW), .LW(LW)) u_lift (
    .clk     (clk),
    .rd_node (l_rd_node),
    .rd_lvl  (l_rd_lvl),
    .rd_anc  (l_rd_anc),
    .rd_min  (l_rd_min),
    .wr_en   (l_wr_en),
    .wr_node (na),
    .wr_lvl  (l_wr_lvl),
    .wr_anc  (l_wr_anc),
    .wr_min  (l_wr_min)
  );

  // The sequencer only leaves idle once the clearing pass is over.
  a_no_work_while_clearing: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !d_busy)
    else $error("sequencer active during clearing pass");

  // A new result only appears out of the delivery state.
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_DONE))
    else $error("result raised outside delivery state");

  // An insert of node zero or one is dropped at once.
  a_low_insert_ignored: assert property (@(posedge clk) disable iff (rst)
    s_accept && s_tuser == OP_INSERT && f_node < ID_W'(2) |=> state == S_IDLE)
    else $error("insert of sentinel or root node not ignored");

endmodule

FILE: verif/tree_path_minimum_query_tb.sv
// Self-checking testbench for the tree path minimum query block.
// Depends on tpmq_pkg and tree_path_minimum_query; drives inserts and path
// queries and checks every result against a binary-lifting predictor.
module tree_path_minimum_query_tb;
  import tpmq_pkg::*;

  localparam int NODES  = 1024;
  localparam int LVL    = 11;
  localparam int WD_LIMIT = 20000;

  typedef struct packed {
    logic    op;
    node_id_t node;
    node_id_t parent;
    weight_t  weight;
    node_id_t first_node;
    node_id_t second_node;
  } tree_item_t;

  typedef struct packed {
    weight_t path_minimum;
    logic    empty_path;
  } path_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tuser;

  tree_path_minimum_query u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #1 clk = ~clk;

  // Predictor copy of the tree.
  node_id_t     lift_up [NODES][LVL];
  weight_t      lift_min [NODES][LVL];
  logic [10:0]  depth_of [NODES];

  tree_item_t   pending_items [$];
  path_result_t expected_minima [$];
  int unsigned  fail_count = 0;
  int unsigned  idle_cycles = 0;
  bit           calm = 1'b0;
  bit           hold_sender = 1'b0;
  int           send_gap = 0;
  int           recv_gap = 0;
  node_id_t     present_nodes [$];

  function automatic weight_t min_w(weight_t x, weight_t y);
    return (x < y) ? x : y;
  endfunction

  task automatic clear_tree();
    for (int n = 0; n < NODES; n++) begin
      depth_of[n] = '0;
      for (int j = 0; j < LVL; j++) begin
        lift_up[n][j] = '0;
        lift_min[n][j] = WEIGHT_ONES;
      end
    end
    depth_of[1] = 11'd1;
    present_nodes = {};
    present_nodes.push_back(node_id_t'(1));
  endtask

  task automatic add_node(node_id_t nd, node_id_t par, weight_t w);
    node_id_t mid;
    if (nd < 2 || depth_of[nd] != 0 || depth_of[par] == 0) return;
    depth_of[nd] = depth_of[par] + 11'd1;
    lift_up[nd][0] = par;
    lift_min[nd][0] = w;
    for (int j = 1; j < LVL; j++) begin
      mid = lift_up[nd][j-1];
      lift_up[nd][j] = lift_up[mid][j-1];
      lift_min[nd][j] = min_w(lift_min[nd][j-1], lift_min[mid][j-1]);
    end
    present_nodes.push_back(nd);
  endtask

  function automatic weight_t climb_minimum(node_id_t a, node_id_t b);
    weight_t  best;
    node_id_t t;
    best = WEIGHT_ONES;
    if (depth_of[a] > depth_of[b]) begin
      t = a; a = b; b = t;
    end
    for (int i = LVL - 1; i >= 0; i--) begin
      if (depth_of[lift_up[b][i]] >= depth_of[a]) begin
        best = min_w(best, lift_min[b][i]);
        b = lift_up[b][i];
      end
    end
    if (a == b) return best;
    for (int i = LVL - 1; i >= 0; i--) begin
      if (lift_up[a][i] != lift_up[b][i]) begin
        best = min_w(best, min_w(lift_min[a][i], lift_min[b][i]));
        a = lift_up[a][i];
        b = lift_up[b][i];
      end
    end
    return min_w(best, min_w(lift_min[a][0], lift_min[b][0]));
  endfunction

  // Apply one accepted item to the predictor.
  task automatic predict_item(tree_item_t it);
    path_result_t r;
    if (it.op == OP_INSERT) begin
      add_node(it.node, it.parent, it.weight);
    end else begin
      r.empty_path = 1'b0;
      r.path_minimum = WEIGHT_ONES;
      if (it.first_node == it.second_node) r.empty_path = 1'b1;
      else if (depth_of[it.first_node] != 0 && depth_of[it.second_node] != 0)
        r.path_minimum = climb_minimum(it.first_node, it.second_node);
      expected_minima.push_back(r);
    end
  endtask

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  function automatic tree_item_t make_insert(node_id_t nd, node_id_t par, weight_t w);
    tree_item_t it;
    it = '0;
    it.op = OP_INSERT;
    it.node = nd; it.parent = par; it.weight = w;
    it.first_node = node_id_t'($urandom); it.second_node = node_id_t'($urandom);
    return it;
  endfunction

  function automatic tree_item_t make_query(node_id_t a, node_id_t b);
    tree_item_t it;
    it = '0;
    it.op = OP_QUERY;
    it.node = node_id_t'($urandom); it.parent = node_id_t'($urandom);
    it.weight = weight_t'($urandom);
    it.first_node = a; it.second_node = b;
    return it;
  endfunction

  // Driver: at most one nonblocking write of each input per edge.
  always @(posedge clk) begin
    tree_item_t it;
    tree_item_t acc;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid && s_tready) begin
        // Unpack the accepted item field by field from the bus.
        acc.op          = s_tuser;
        acc.node        = s_tdata[9:0];
        acc.parent      = s_tdata[19:10];
        acc.weight      = s_tdata[43:20];
        acc.first_node  = s_tdata[53:44];
        acc.second_node = s_tdata[63:54];
        predict_item(acc);
      end
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (hold_sender || pending_items.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        send_gap <= $urandom_range(0, 3);
        s_tvalid <= 1'b0;
      end else begin
        it = pending_items.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= it.op;
        s_tdata <= {it.second_node, it.first_node, it.weight, it.parent, it.node};
      end
    end
  end

  // Monitor and receiver stalls.
  always @(posedge clk) begin
    path_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_minima.size() == 0) begin
          report_mismatch("unexpected result", m_tdata, 0);
        end else begin
          want = expected_minima.pop_front();
          if (m_tdata != want.path_minimum)
            report_mismatch("path_minimum", m_tdata, want.path_minimum);
          if (m_tuser != want.empty_path)
            report_mismatch("empty_path", m_tuser, want.empty_path);
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        recv_gap <= $urandom_range(0, 3);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no handshake.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("tree_path_minimum_query regression: fail");
      $finish;
    end
  end

  function automatic node_id_t pick_present();
    return present_nodes[$urandom_range(0, present_nodes.size() - 1)];
  endfunction

  // Random well-formed stream, mostly valid inserts and queries on present nodes.
  task automatic queue_random(int count, ref bit used [NODES], ref node_id_t known [$]);
    node_id_t nd;
    int k;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 19);
      if (k < 7) begin
        nd = node_id_t'($urandom_range(2, NODES - 1));
        if (!used[nd]) begin
          used[nd] = 1'b1;
          pending_items.push_back(make_insert(nd, known[$urandom_range(0, known.size() - 1)],
                                              weight_t'($urandom)));
          known.push_back(nd);
        end else begin
          pending_items.push_back(make_insert(nd, node_id_t'($urandom), weight_t'($urandom)));
        end
      end else if (k < 8) begin
        pending_items.push_back(make_insert(node_id_t'($urandom), node_id_t'($urandom),
                                            weight_t'($urandom)));
      end else if (k < 18) begin
        pending_items.push_back(make_query(known[$urandom_range(0, known.size() - 1)],
                                           known[$urandom_range(0, known.size() - 1)]));
      end else begin
        pending_items.push_back(make_query(node_id_t'($urandom), node_id_t'($urandom)));
      end
    end
  endtask

  initial begin
    bit       used [NODES];
    node_id_t known [$];
    int       settle;
    clear_tree();
    foreach (used[n]) used[n] = 1'b0;
    used[0] = 1'b1; used[1] = 1'b1;
    known.push_back(node_id_t'(1));
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, a chain, ignored inserts, empty and absent queries.
    pending_items.push_back(make_insert(10'd2, 10'd1, 24'd0));
    pending_items.push_back(make_insert(10'd1023, 10'd2, 24'hFFFFFE));
    pending_items.push_back(make_insert(10'd512, 10'd1023, 24'h800000));
    pending_items.push_back(make_insert(10'd3, 10'd1, 24'h000123));
    pending_items.push_back(make_insert(10'd0, 10'd1, 24'd5));
    pending_items.push_back(make_insert(10'd1, 10'd2, 24'd5));
    pending_items.push_back(make_insert(10'd2, 10'd3, 24'd7));
    pending_items.push_back(make_insert(10'd4, 10'd700, 24'd7));
    pending_items.push_back(make_insert(10'd5, 10'd0, 24'hFFFFFF));
    pending_items.push_back(make_query(10'd512, 10'd3));
    pending_items.push_back(make_query(10'd3, 10'd512));
    pending_items.push_back(make_query(10'd1, 10'd1023));
    pending_items.push_back(make_query(10'd1023, 10'd2));
    pending_items.push_back(make_query(10'd7, 10'd7));
    pending_items.push_back(make_query(10'd0, 10'd0));
    pending_items.push_back(make_query(10'd1, 10'd700));
    pending_items.push_back(make_query(10'd0, 10'd2));
    used[2] = 1'b1; used[1023] = 1'b1; used[512] = 1'b1; used[3] = 1'b1;
    known.push_back(node_id_t'(2)); known.push_back(node_id_t'(1023));
    known.push_back(node_id_t'(512)); known.push_back(node_id_t'(3));

    // Deep chain so the upper lift levels come into play.
    for (int d = 0; d < 12; d++) begin
      node_id_t nd;
      nd = node_id_t'(600 + d);
      used[nd] = 1'b1;
      pending_items.push_back(make_insert(nd, known[known.size() - 1], weight_t'($urandom)));
      known.push_back(nd);
    end
    queue_random(1000, used, known);

    // Sender holds off until every query result is back.
    wait (pending_items.size() == 0);
    hold_sender = 1'b1;
    wait (expected_minima.size() == 0 && s_tvalid == 1'b0);
    hold_sender = 1'b0;

    queue_random(800, used, known);
    wait (pending_items.size() == 0);
    calm = 1'b1;
    queue_random(200, used, known);
    wait (pending_items.size() == 0 && s_tvalid == 1'b0);
    wait (expected_minima.size() == 0);
    settle = 0;
    while (settle < 200) begin
      @(posedge clk);
      settle++;
    end
    if (fail_count == 0 && expected_minima.size() == 0) begin
      $display("tree_path_minimum_query regression: pass");
    end else begin
      $display("tree_path_minimum_query regression: fail");
    end
    $finish;
  end

endmodule
